/* hw/rtl/imu_heading_fault_monitor_unit_macros.svh */
// Assertion macros used by the heading fault monitor checker.
`ifndef IMU_HEADING_FAULT_MONITOR_UNIT_MACROS_SVH
`define IMU_HEADING_FAULT_MONITOR_UNIT_MACROS_SVH

// Same-cycle implication, checked at each rising edge of clk unless dis is high.
`define HFM_ASSERT_SAME(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("hfm assertion failed");

// Next-cycle implication, checked at each rising edge of clk unless dis is high.
`define HFM_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("hfm assertion failed");

`endif

/* hw/rtl/hfm_pkg.sv */
// Types and constants of the heading fault monitor.
package hfm_pkg;

    localparam logic [15:0] HALF_TURN_CDEG = 16'd18000;
    localparam logic [15:0] FULL_TURN_CDEG = 16'd36000;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_COURSE_TIMEOUT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_TIMEOUT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DIFF        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_LIMIT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESTART_TIMEOUT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIM_MODE        = 3'd5;

    localparam logic [31:0] RST_COURSE_TIMEOUT  = 32'd10000;
    localparam logic [31:0] RST_DATA_TIMEOUT    = 32'd10000;
    localparam logic [14:0] RST_MAX_DIFF        = 15'd4500;
    localparam logic [7:0]  RST_CHECK_LIMIT     = 8'd5;
    localparam logic [31:0] RST_RESTART_TIMEOUT = 32'd60000;
    localparam logic [7:0]  COUNT_ONE           = 8'd1;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        health_ok;
        logic        in_monitored_state;
        logic        heading_valid;
        logic [15:0] heading_cdeg;
        logic        course_valid;
        logic [15:0] course_cdeg;
        logic [31:0] course_age_ms;
        logic        heading_seen;
        logic [31:0] heading_age_ms;
    } hfm_in_t;

    typedef struct packed {
        logic fault_latched;
        logic report_by_mismatch;
        logic report_by_stale;
    } hfm_out_t;

endpackage

/* hw/rtl/imu_heading_fault_monitor_unit.sv */
// Heading fault monitor: compares compass heading with course over ground and latches faults.
// One request per cycle: a tick is taken into an input register, checked by one pass of
// compare, staleness and counter logic against the held state, and its result is registered
// into the output register once it is empty or being drained; a new tick is accepted every
// cycle as long as the output register is empty or being drained, so throughput is one tick
// per clock while the output is not stalled. Configuration writes take effect at once
// and are meant to be issued only while no tick is in flight.
module imu_heading_fault_monitor_unit
    import hfm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  hfm_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output hfm_out_t               m_data
);

    logic [31:0] course_timeout_reg;
    logic [31:0] data_timeout_reg;
    logic [14:0] max_diff_reg;
    logic [7:0]  check_limit_reg;
    logic [31:0] restart_timeout_reg;
    logic        sim_mode_reg;

    hfm_in_t     in_reg;
    logic        in_valid_reg;
    hfm_out_t    out_reg;
    hfm_out_t    out_next;
    logic        out_valid_reg;

    logic [15:0] prev_course_reg, prev_course_next;
    logic [7:0]  mis_cnt_reg, mis_cnt_next;
    logic [7:0]  stale_cnt_reg, stale_cnt_next;
    logic        fault_reg, fault_next;
    logic [31:0] last_report_reg, last_report_next;

    logic        fire;
    logic        det_en;
    logic        course_new;
    logic [15:0] raw_diff;
    logic [15:0] circ_diff;
    logic        mis_bad;
    logic        stale_bad;
    logic        mis_rep;
    logic        stale_rep;
    logic        raise;
    logic [31:0] elapsed;
    logic        restart_clear;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        det_en = in_reg.health_ok && !fault_reg && !sim_mode_reg && in_reg.in_monitored_state;
        course_new = in_reg.heading_valid && in_reg.course_valid
                     && (in_reg.course_age_ms <= course_timeout_reg)
                     && (prev_course_reg != in_reg.course_cdeg);
        raw_diff = (in_reg.heading_cdeg >= in_reg.course_cdeg)
                   ? in_reg.heading_cdeg - in_reg.course_cdeg
                   : in_reg.course_cdeg - in_reg.heading_cdeg;
        if (raw_diff <= HALF_TURN_CDEG) begin
            circ_diff = raw_diff;
        end else if (raw_diff >= FULL_TURN_CDEG) begin
            circ_diff = '0;
        end else begin
            circ_diff = FULL_TURN_CDEG - raw_diff;
        end
        mis_bad   = course_new && (circ_diff >= {1'b0, max_diff_reg});
        stale_bad = !in_reg.heading_seen || (in_reg.heading_age_ms > data_timeout_reg);
        mis_rep   = det_en && mis_bad && !(mis_cnt_reg < check_limit_reg);
        stale_rep = det_en && stale_bad && !(stale_cnt_reg < check_limit_reg);
        raise     = mis_rep || stale_rep;

        prev_course_next = (det_en && course_new) ? in_reg.course_cdeg : prev_course_reg;

        if (!det_en) begin
            mis_cnt_next = mis_cnt_reg;
        end else if (raise || !mis_bad) begin
            mis_cnt_next = COUNT_ONE;
        end else begin
            mis_cnt_next = mis_cnt_reg + COUNT_ONE;
        end

        if (!det_en) begin
            stale_cnt_next = stale_cnt_reg;
        end else if (raise || !stale_bad) begin
            stale_cnt_next = COUNT_ONE;
        end else begin
            stale_cnt_next = stale_cnt_reg + COUNT_ONE;
        end

        last_report_next = raise ? in_reg.now_ms : last_report_reg;

        elapsed       = in_reg.now_ms - last_report_reg;
        restart_clear = in_reg.health_ok && !raise && (elapsed > restart_timeout_reg);

        if (raise) begin
            fault_next = 1'b1;
        end else if (restart_clear) begin
            fault_next = 1'b0;
        end else begin
            fault_next = fault_reg;
        end

        out_next.fault_latched      = fault_next;
        out_next.report_by_mismatch = mis_rep;
        out_next.report_by_stale    = stale_rep;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            course_timeout_reg  <= RST_COURSE_TIMEOUT;
            data_timeout_reg    <= RST_DATA_TIMEOUT;
            max_diff_reg        <= RST_MAX_DIFF;
            check_limit_reg     <= RST_CHECK_LIMIT;
            restart_timeout_reg <= RST_RESTART_TIMEOUT;
            sim_mode_reg        <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_COURSE_TIMEOUT:  course_timeout_reg  <= cfg_wdata;
                CFG_DATA_TIMEOUT:    data_timeout_reg    <= cfg_wdata;
                CFG_MAX_DIFF:        max_diff_reg        <= cfg_wdata[14:0];
                CFG_CHECK_LIMIT:     check_limit_reg     <= cfg_wdata[7:0];
                CFG_RESTART_TIMEOUT: restart_timeout_reg <= cfg_wdata;
                CFG_SIM_MODE:        sim_mode_reg        <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            prev_course_reg <= '0;
            mis_cnt_reg     <= COUNT_ONE;
            stale_cnt_reg   <= COUNT_ONE;
            fault_reg       <= 1'b0;
            last_report_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg   <= 1'b1;
                prev_course_reg <= prev_course_next;
                mis_cnt_reg     <= mis_cnt_next;
                stale_cnt_reg   <= stale_cnt_next;
                fault_reg       <= fault_next;
                last_report_reg <= last_report_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (fire) begin
            out_reg <= out_next;
        end
    end

endmodule

/* hw/rtl/hfm_checker.sv */
// Port-level checker for the heading fault monitor and its bind.
`include "imu_heading_fault_monitor_unit_macros.svh"

module hfm_checker
    import hfm_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input hfm_out_t               m_data
);

    logic any_report;

    assign any_report = m_data.report_by_mismatch || m_data.report_by_stale;

    `HFM_ASSERT_SAME(a_report_sets_fault, aclk, !aresetn, m_valid && any_report, m_data.fault_latched)
    `HFM_ASSERT_SAME(a_stall_only_on_full_output, aclk, !aresetn, !s_ready, m_valid)
    `HFM_ASSERT_NEXT(a_reset_empties_output, aclk, 1'b0, !aresetn, !m_valid)
    `HFM_ASSERT_NEXT(a_result_holds, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule

bind imu_heading_fault_monitor_unit hfm_checker u_hfm_checker (.*);
